### rtl/rlbd_pkg.sv
// Shared types, constants and codes for the resistor-ladder keypad decoder.
package rlbd_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int BUTTON_W  = 3;
    localparam int HOLD_W    = 16;
    localparam int IVAL_W    = 8;
    localparam int TICK_W    = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [BUTTON_W-1:0]   t_button;
    typedef logic [HOLD_W-1:0]     t_hold;
    typedef logic [IVAL_W-1:0]     t_ival;
    typedef logic [TICK_W-1:0]     t_tick;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [1:0] {
        EV_QUICK_RELEASE = 2'd0,
        EV_LONG_BEGIN    = 2'd1,
        EV_LONG_RELEASE  = 2'd2
    } t_event_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HOLD_PERIOD     = 2'd0,
        CFG_SAMPLE_INTERVAL = 2'd1,
        CFG_SINGLE_SWITCH   = 2'd2
    } t_cfg_index;

    localparam t_hold HOLD_PERIOD_RST     = 16'd1000;
    localparam t_ival SAMPLE_INTERVAL_RST = 8'd50;

    localparam t_button BTN_NONE = 3'd0;
    localparam t_button BTN_1    = 3'd1;
    localparam t_button BTN_2    = 3'd2;
    localparam t_button BTN_3    = 3'd3;
    localparam t_button BTN_4    = 3'd4;

    // Windows on sample/10, open at both ends.
    localparam int DIV        = 10;
    localparam int NONE_V_LO  = 95;
    localparam int NONE_V_HI  = 105;
    localparam int B1_V_LO    = 82;
    localparam int B1_V_HI    = 94;
    localparam int B2_V_LO    = 70;
    localparam int B2_V_HI    = 81;
    localparam int B3_V_LO    = 50;
    localparam int B3_V_HI    = 70;
    localparam int B4_V_HI    = 10;
    localparam int SINGLE_RAW_HI = 3;

    // Same windows moved onto the raw sample: v > lo <=> raw >= (lo+1)*DIV,
    // v < hi <=> raw < hi*DIV.
    localparam int RAW_W = SAMPLE_W + 1;
    localparam logic [RAW_W-1:0] NONE_RAW_LO = RAW_W'((NONE_V_LO + 1) * DIV);
    localparam logic [RAW_W-1:0] NONE_RAW_HI = RAW_W'(NONE_V_HI * DIV);
    localparam logic [RAW_W-1:0] B1_RAW_LO   = RAW_W'((B1_V_LO + 1) * DIV);
    localparam logic [RAW_W-1:0] B1_RAW_HI   = RAW_W'(B1_V_HI * DIV);
    localparam logic [RAW_W-1:0] B2_RAW_LO   = RAW_W'((B2_V_LO + 1) * DIV);
    localparam logic [RAW_W-1:0] B2_RAW_HI   = RAW_W'(B2_V_HI * DIV);
    localparam logic [RAW_W-1:0] B3_RAW_LO   = RAW_W'((B3_V_LO + 1) * DIV);
    localparam logic [RAW_W-1:0] B3_RAW_HI   = RAW_W'(B3_V_HI * DIV);
    localparam logic [RAW_W-1:0] B4_RAW_HI   = RAW_W'(B4_V_HI * DIV);
    localparam logic [RAW_W-1:0] SINGLE_RAW  = RAW_W'(SINGLE_RAW_HI);

    typedef struct packed {
        t_button button;
        logic    keep;        // sample outside every window
        logic    clear_hold;  // no-key window seen
    } t_decode;

endpackage

### rtl/rlbd_decode.sv
// Sample-to-button window decoder for ladder and single-switch modes.
module rlbd_decode (
    input  rlbd_pkg::t_sample i_adc_sample,
    input  logic              i_single_switch,
    output rlbd_pkg::t_decode o_decode
);
    import rlbd_pkg::*;

    logic [RAW_W-1:0] raw;

    assign raw = {1'b0, i_adc_sample};

    always_comb begin
        o_decode = '{button: BTN_NONE, keep: 1'b0, clear_hold: 1'b0};
        if (i_single_switch) begin
            if (raw < SINGLE_RAW) begin
                o_decode.button = BTN_1;
            end else begin
                o_decode.clear_hold = 1'b1;
            end
        end else if (raw >= NONE_RAW_LO && raw < NONE_RAW_HI) begin
            o_decode.clear_hold = 1'b1;
        end else if (raw >= B1_RAW_LO && raw < B1_RAW_HI) begin
            o_decode.button = BTN_1;
        end else if (raw >= B2_RAW_LO && raw < B2_RAW_HI) begin
            o_decode.button = BTN_2;
        end else if (raw >= B3_RAW_LO && raw < B3_RAW_HI) begin
            o_decode.button = BTN_3;
        end else if (raw < B4_RAW_HI) begin
            o_decode.button = BTN_4;
        end else begin
            o_decode.keep = 1'b1;
        end
    end

endmodule

### rtl/resistor_ladder_button_decoder_top.sv
// Top level of the resistor-ladder keypad decoder with long-press detection.
//
// Can take a new sample in every clock cycle; a result, when a tick causes
// one, is loaded into the output register on the sample transfer. The input
// side stalls only while that output register holds a result that the
// receiver is stalling, so while the receiver does not stall the sustained
// rate is one sample per cycle, set by the single combinational pass from the
// sample port and the state registers into the result register.
module resistor_ladder_button_decoder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  rlbd_pkg::t_cfg_addr   i_cfg_addr,
    input  rlbd_pkg::t_cfg_data   i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rlbd_pkg::t_sample     i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rlbd_pkg::t_button     o_button,
    output rlbd_pkg::t_event_kind o_event_kind
);
    import rlbd_pkg::*;

    localparam t_tick TICK_MAX = '1;
    localparam t_hold HOLD_MAX = '1;

    t_hold       r_hold_period;
    t_ival       r_sample_interval;
    logic        r_single_switch;

    t_tick       r_ticks, n_ticks;
    t_hold       r_held, n_held;
    t_button     r_cur, n_cur;
    logic        r_long, n_long;
    logic        r_hold_rep, n_hold_rep;

    logic        r_out_valid, n_out_valid;
    t_button     r_out_button, n_out_button;
    t_event_kind r_out_kind, n_out_kind;

    t_decode     dec;
    logic        in_xfer;
    logic        out_xfer;
    t_tick       ticks_inc;
    t_hold       held_inc;
    t_button     nb;
    logic        hold_rep_d;
    logic        res_valid;
    t_button     res_button;
    t_event_kind res_kind;

    rlbd_decode u_decode (
        .i_adc_sample    (i_adc_sample),
        .i_single_switch (r_single_switch),
        .o_decode        (dec)
    );

    assign out_xfer   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign ticks_inc = (r_ticks != TICK_MAX) ? r_ticks + 1'b1 : r_ticks;
    assign held_inc  = (r_held != HOLD_MAX) ? r_held + 1'b1 : r_held;

    always_comb begin
        n_ticks    = ticks_inc;
        n_held     = held_inc;
        n_cur      = r_cur;
        n_long     = r_long;
        n_hold_rep = r_hold_rep;
        nb         = r_cur;
        hold_rep_d = r_hold_rep;
        res_valid  = 1'b0;
        res_button = r_cur;
        res_kind   = EV_QUICK_RELEASE;

        if (ticks_inc > {1'b0, r_sample_interval}) begin
            n_ticks    = '0;
            nb         = dec.keep ? r_cur : dec.button;
            hold_rep_d = dec.clear_hold ? 1'b0 : r_hold_rep;
            if (nb != r_cur) begin
                n_held = '0;
                if (nb == BTN_NONE) begin
                    res_valid  = 1'b1;
                    res_button = r_cur;
                    res_kind   = r_long ? EV_LONG_RELEASE : EV_QUICK_RELEASE;
                end
            end
            n_cur      = nb;
            n_hold_rep = hold_rep_d;
            if (n_held > r_hold_period && nb != BTN_NONE) begin
                n_long = 1'b1;
                if (!hold_rep_d) begin
                    n_hold_rep = 1'b1;
                    res_valid  = 1'b1;
                    res_button = nb;
                    res_kind   = EV_LONG_BEGIN;
                end
            end else begin
                n_long = 1'b0;
            end
        end
    end

    // Output register: load on a sample transfer, drop once taken.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_button = r_out_button;
        n_out_kind   = r_out_kind;
        if (in_xfer) begin
            n_out_valid  = res_valid;
            n_out_button = res_button;
            n_out_kind   = res_kind;
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_period     <= HOLD_PERIOD_RST;
            r_sample_interval <= SAMPLE_INTERVAL_RST;
            r_single_switch   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HOLD_PERIOD:     r_hold_period     <= i_cfg_wdata;
                CFG_SAMPLE_INTERVAL: r_sample_interval <= i_cfg_wdata[IVAL_W-1:0];
                CFG_SINGLE_SWITCH:   r_single_switch   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= '0;
            r_held      <= '0;
            r_cur       <= BTN_NONE;
            r_long      <= 1'b0;
            r_hold_rep  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_ticks    <= n_ticks;
                r_held     <= n_held;
                r_cur      <= n_cur;
                r_long     <= n_long;
                r_hold_rep <= n_hold_rep;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_button <= n_out_button;
        r_out_kind   <= n_out_kind;
    end

    assign o_out_valid  = r_out_valid;
    assign o_button     = r_out_button;
    assign o_event_kind = r_out_kind;

endmodule

### rtl/rlbd_checker.sv
// Port-level assertions for the keypad decoder, bound to the top level.
module rlbd_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  rlbd_pkg::t_button     o_button,
    input  rlbd_pkg::t_event_kind o_event_kind
);
    import rlbd_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_button) && $stable(o_event_kind))
        else $error("stalled result changed");

    // A new result only follows a sample transfer.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result without sample transfer");

    // Events always name a real key and a defined kind.
    a_out_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_button != BTN_NONE) && (o_button <= BTN_4) &&
            (o_event_kind == EV_QUICK_RELEASE || o_event_kind == EV_LONG_BEGIN ||
             o_event_kind == EV_LONG_RELEASE))
        else $error("illegal result fields");

    // Stall the input only while a result waits on a stalled receiver.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without backpressure");

endmodule

bind resistor_ladder_button_decoder_top rlbd_checker u_rlbd_checker (.*);
